>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/pmu_pkg.sv
// ----------------------------------------------------------------------------
// Pheromone matrix update package
// Sizes, command and register codes, and shared types.
// ----------------------------------------------------------------------------
package pmu_pkg;
   localparam int MAX_NODES    = 128;
   localparam int NODE_BITS    = $clog2(MAX_NODES);
   localparam int ADDR_BITS    = 2 * NODE_BITS;
   localparam int DEPTH        = MAX_NODES * MAX_NODES;
   localparam int DIV_BITS     = 46;
   localparam int DIVISOR_BITS = 24;
   localparam int STEP_BITS    = 6;

   localparam logic [2:0] CMD_FILL    = 3'd0;
   localparam logic [2:0] CMD_EVAP    = 3'd1;
   localparam logic [2:0] CMD_DEPOSIT = 3'd2;
   localparam logic [2:0] CMD_DISTURB = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;

   localparam logic [1:0] REG_RHO   = 2'd0;
   localparam logic [1:0] REG_DELTA = 2'd1;
   localparam logic [1:0] REG_NODES = 2'd2;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;
endpackage

>>> rtl/pmu_divider.sv
// ----------------------------------------------------------------------------
// Pheromone matrix divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmu_divider
   import pmu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_BITS-1:0]     dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output div_rsp_type             rsp
);
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] dvs_ff, dvs_in;
   logic [STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIVISOR_BITS:0]   shifted;
   logic                    ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_BITS'(shifted - {1'b0, dvs_ff})
                     : DIVISOR_BITS'(shifted);
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

>>> rtl/pheromone_matrix_update.sv
// ----------------------------------------------------------------------------
// Pheromone matrix update engine
// Keeps the Q8.24 pheromone matrix in one RAM and runs fill, evaporate,
// deposit, disturb and read commands against it.
// ----------------------------------------------------------------------------
// One command is worked at a time, and every command returns one result beat.
// With n the active side, a fill writes all n*n entries, an evaporate reads,
// scales and writes back each off-diagonal entry, a disturb sums all entries,
// divides for the mean and blends each entry with it, and a deposit divides
// and updates one entry. The single-port matrix RAM, one access per cycle,
// sets the sweep times, and the 46-step serial divider sets the deposit time
// and the mean of a disturb. Entries are undefined until the first fill.
module pheromone_matrix_update
   import pmu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_from_node,
   input  logic [6:0]  req_to_node,
   input  logic [31:0] req_fill_value,
   input  logic [7:0]  req_rank_weight,
   input  logic [23:0] req_tour_length,
   input  logic        req_tour_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic        rsp_saturated,
   output logic        rsp_tour_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
`include "assert_macros.svh"

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_FILL   = 17'h00002,
      S_EVRD   = 17'h00004,
      S_EVMUL  = 17'h00008,
      S_EVWR   = 17'h00010,
      S_DIVW   = 17'h00020,
      S_DPRD   = 17'h00040,
      S_DPWR   = 17'h00080,
      S_SUMRD  = 17'h00100,
      S_SUMACC = 17'h00200,
      S_MEANW  = 17'h00400,
      S_MTERM  = 17'h00800,
      S_DSRD   = 17'h01000,
      S_DSMUL  = 17'h02000,
      S_DSWR   = 17'h04000,
      S_RDRD   = 17'h08000,
      S_DONE   = 17'h10000
   } state_type;

   state_type             state_ff, state_in;
   logic [15:0]           rho_ff, delta_ff;
   logic [7:0]            nodes_ff;
   logic [NODE_BITS-1:0]  row_ff, row_in, col_ff, col_in;
   logic [31:0]           fill_ff, fill_in;
   logic [31:0]           amount_ff, amount_in;
   logic [31:0]           mean_ff, mean_in;
   logic [48:0]           prod_ff, prod_in;
   logic [48:0]           mterm_ff, mterm_in;
   logic [DIV_BITS-1:0]   total_ff, total_in;
   logic [31:0]           res_value_ff, res_value_in;
   logic                  res_sat_ff, res_sat_in;
   logic                  res_done_ff, res_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic                  prev_read_ff;

   logic [31:0]           trail_mem [DEPTH];
   logic [31:0]           rd_data_ff;
   logic                  mem_we, mem_re;
   logic [31:0]           mem_wdata;
   logic [ADDR_BITS-1:0]  mem_addr;

   logic                  div_start;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [DIVISOR_BITS-1:0] div_divisor;
   div_rsp_type           div_rsp;

   logic [7:0]            n_eff;
   logic                  last_col, last_row, sweep_last, accept, slot_free;
   logic                  in_range;
   logic [16:0]           keep_evap, keep_mean;
   logic [32:0]           dep_sum;
   logic [DIV_BITS-1:0]   total_next;
   logic [48:0]           blend;

   pmu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .rsp      (div_rsp)
   );

   always_comb begin
      if (nodes_ff < 8'd2) begin
         n_eff = 8'd2;
      end else if (nodes_ff > 8'(MAX_NODES)) begin
         n_eff = 8'(MAX_NODES);
      end else begin
         n_eff = nodes_ff;
      end
   end

   assign last_col   = {1'b0, col_ff} == n_eff - 8'd1;
   assign last_row   = {1'b0, row_ff} == n_eff - 8'd1;
   assign sweep_last = last_col && last_row;
   assign mem_addr   = {row_ff, col_ff};
   assign accept     = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range   = ({1'b0, req_from_node} < n_eff) && ({1'b0, req_to_node} < n_eff);
   assign keep_evap  = 17'h10000 - {1'b0, rho_ff};
   assign keep_mean  = 17'h10000 - {1'b0, delta_ff};
   assign dep_sum    = {1'b0, rd_data_ff} + {1'b0, amount_ff};
   assign total_next = total_ff + DIV_BITS'(rd_data_ff);
   assign blend      = mterm_ff + prod_ff;

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_tour_done  = rsp_done_ff;
   assign csr_ready      = 1'b1;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fill_in      = fill_ff;
      amount_in    = amount_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      mterm_in     = mterm_ff;
      total_in     = total_ff;
      res_value_in = res_value_ff;
      res_sat_in   = res_sat_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_done_in  = rsp_done_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = fill_ff;
      div_start    = 1'b0;
      div_dividend = DIV_BITS'({req_rank_weight, 24'd0});
      div_divisor  = (req_tour_length == 24'd0) ? 24'd1 : req_tour_length;

      if (state_ff == S_FILL || state_ff == S_EVWR || state_ff == S_SUMACC ||
          state_ff == S_DSWR || (state_ff == S_EVRD && row_ff == col_ff)) begin
         if (sweep_last) begin
            row_in = '0;
            col_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_value_in = '0;
               res_sat_in   = 1'b0;
               res_done_in  = 1'b0;
               row_in       = '0;
               col_in       = '0;
               fill_in      = req_fill_value;
               total_in     = '0;
               case (req_cmd)
                  CMD_FILL:    state_in = S_FILL;
                  CMD_EVAP:    state_in = S_EVRD;
                  CMD_DISTURB: state_in = S_SUMRD;
                  CMD_DEPOSIT: begin
                     res_done_in = req_tour_end;
                     row_in      = req_from_node;
                     col_in      = req_to_node;
                     if (in_range) begin
                        div_start = 1'b1;
                        state_in  = S_DIVW;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  CMD_READ: begin
                     row_in   = req_from_node;
                     col_in   = req_to_node;
                     state_in = in_range ? S_RDRD : S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            if (sweep_last) state_in = S_DONE;
         end
         S_EVRD: begin
            if (row_ff == col_ff) begin
               if (sweep_last) state_in = S_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_EVMUL;
            end
         end
         S_EVMUL: begin
            prod_in  = {17'd0, rd_data_ff} * {32'd0, keep_evap};
            state_in = S_EVWR;
         end
         S_EVWR: begin
            mem_we    = 1'b1;
            mem_wdata = prod_ff[47:16];
            state_in  = sweep_last ? S_DONE : S_EVRD;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               amount_in = div_rsp.quotient[31:0];
               state_in  = S_DPRD;
            end
         end
         S_DPRD: begin
            mem_re   = 1'b1;
            state_in = S_DPWR;
         end
         S_DPWR: begin
            mem_we     = 1'b1;
            mem_wdata  = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
            res_sat_in = dep_sum[32];
            state_in   = S_DONE;
         end
         S_SUMRD: begin
            mem_re   = 1'b1;
            state_in = S_SUMACC;
         end
         S_SUMACC: begin
            total_in = total_next;
            if (sweep_last) begin
               div_start    = 1'b1;
               div_dividend = total_next;
               div_divisor  = DIVISOR_BITS'({8'd0, n_eff} * {8'd0, n_eff});
               state_in     = S_MEANW;
            end else begin
               state_in = S_SUMRD;
            end
         end
         S_MEANW: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[31:0];
               state_in = S_MTERM;
            end
         end
         S_MTERM: begin
            mterm_in = {17'd0, mean_ff} * {32'd0, keep_mean};
            state_in = S_DSRD;
         end
         S_DSRD: begin
            mem_re   = 1'b1;
            state_in = S_DSMUL;
         end
         S_DSMUL: begin
            prod_in  = {17'd0, rd_data_ff} * {33'd0, delta_ff};
            state_in = S_DSWR;
         end
         S_DSWR: begin
            mem_we    = 1'b1;
            mem_wdata = blend[47:16];
            state_in  = sweep_last ? S_DONE : S_DSRD;
         end
         S_RDRD: begin
            mem_re   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_sat_in   = res_sat_ff;
               rsp_done_in  = res_done_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (state_ff == S_DONE && res_value_ff == 32'd0 && prev_read_ff) begin
         rsp_value_in = slot_free ? rd_data_ff : rsp_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_read_ff <= 1'b0;
      end else begin
         prev_read_ff <= (state_ff == S_RDRD) || (prev_read_ff && state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         trail_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= trail_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      fill_ff      <= fill_in;
      amount_ff    <= amount_in;
      mean_ff      <= mean_in;
      prod_ff      <= prod_in;
      mterm_ff     <= mterm_in;
      total_ff     <= total_in;
      res_value_ff <= res_value_in;
      res_sat_ff   <= res_sat_in;
      res_done_ff  <= res_done_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rho_ff       <= 16'd6554;
         delta_ff     <= 16'd45875;
         nodes_ff     <= 8'd128;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RHO:   rho_ff   <= csr_data;
               REG_DELTA: delta_ff <= csr_data;
               REG_NODES: nodes_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   `ASSERT_IMPLY(a_write_in_side, clock, reset, mem_we,
      ({1'b0, row_ff} < n_eff) && ({1'b0, col_ff} < n_eff))
   `ASSERT_IMPLY(a_no_diag_evap, clock, reset, state_ff == S_EVWR, row_ff != col_ff)
   `ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_DONE)
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pheromone matrix engine testbench
// Runs directed and random fill, evaporate, deposit, disturb, read and unknown
// commands at several register settings. Each result beat is checked against
// a matrix model that is kept inside the scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
   import pmu_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   class trail_scoreboard;
      typedef struct {
         bit [31:0] value;
         bit        sat;
         bit        done;
      } outcome_type;

      bit [31:0] trail [MAX_NODES*MAX_NODES];
      bit [15:0] rho;
      bit [15:0] delta;
      bit [7:0]  nodes_reg;
      outcome_type pending [$];
      int        errors;
      int        checked;
      int        saturations;
      int        per_cmd [8];

      function new();
         rho = 16'd6554;
         delta = 16'd45875;
         nodes_reg = 8'd128;
      endfunction

      function int side();
         if (nodes_reg < 2) return 2;
         if (nodes_reg > MAX_NODES) return MAX_NODES;
         return nodes_reg;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            REG_RHO:   rho = data;
            REG_DELTA: delta = data;
            REG_NODES: nodes_reg = data[7:0];
            default: ;
         endcase
      endfunction

      function void note(logic [2:0] cmd, logic [6:0] from, logic [6:0] to,
                         logic [31:0] fillv, logic [7:0] weight,
                         logic [23:0] len, logic tend);
         outcome_type      o;
         int               n;
         longint unsigned  total, mean, amount, sum, keep;
         o = '{0, 0, 0};
         n = side();
         per_cmd[cmd]++;
         case (cmd)
            CMD_FILL:
               for (int r = 0; r < n; r++)
                  for (int c = 0; c < n; c++) trail[r*MAX_NODES+c] = fillv;
            CMD_EVAP: begin
               keep = 65536 - rho;
               for (int r = 0; r < n; r++)
                  for (int c = 0; c < n; c++)
                     if (r != c)
                        trail[r*MAX_NODES+c] =
                           32'((trail[r*MAX_NODES+c] * keep) >> 16);
            end
            CMD_DEPOSIT: begin
               o.done = tend;
               if (from < n && to < n) begin
                  amount = (longint'(weight) << 24) / ((len == 0) ? 1 : len);
                  sum = trail[from*MAX_NODES+to] + amount;
                  if (sum > 64'hFFFF_FFFF) begin
                     sum = 64'hFFFF_FFFF;
                     o.sat = 1;
                  end
                  trail[from*MAX_NODES+to] = sum[31:0];
               end
            end
            CMD_DISTURB: begin
               total = 0;
               for (int r = 0; r < n; r++)
                  for (int c = 0; c < n; c++) total += trail[r*MAX_NODES+c];
               mean = total / (n * n);
               for (int r = 0; r < n; r++)
                  for (int c = 0; c < n; c++)
                     trail[r*MAX_NODES+c] = 32'(((65536 - delta) * mean
                        + delta * longint'(trail[r*MAX_NODES+c])) >> 16);
            end
            CMD_READ:
               if (from < n && to < n) o.value = trail[from*MAX_NODES+to];
            default: ;
         endcase
         pending.push_back(o);
      endfunction

      function void check(logic [31:0] value, logic sat, logic done);
         outcome_type o;
         if (pending.size() == 0) begin
            $error("result beat with no command outstanding");
            errors++;
            return;
         end
         o = pending.pop_front();
         checked++;
         if (sat) saturations++;
         if (value !== o.value) begin
            $error("read_value: expected %h, got %h", o.value, value);
            errors++;
         end
         if (sat !== o.sat) begin
            $error("saturated: expected %0d, got %0d", o.sat, sat);
            errors++;
         end
         if (done !== o.done) begin
            $error("tour_done: expected %0d, got %0d", o.done, done);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_READ;
   logic [6:0]  req_from_node = 0;
   logic [6:0]  req_to_node = 0;
   logic [31:0] req_fill_value = 0;
   logic [7:0]  req_rank_weight = 0;
   logic [23:0] req_tour_length = 1;
   logic        req_tour_end = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_read_value;
   logic        rsp_saturated;
   logic        rsp_tour_done;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_RHO;
   logic [15:0] csr_data = 0;

   trail_scoreboard sb = new();
   int              idle_cycles = 0;
   int              stall_left = 0;
   int              items_sent = 0;
   int              phases_run = 0;

   pheromone_matrix_update u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_valid && !rsp_stall)
            sb.check(rsp_read_value, rsp_saturated, rsp_tour_done);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            stall_left = idle_gap();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   task automatic send(logic [2:0] cmd, logic [6:0] from, logic [6:0] to,
                       logic [31:0] fillv, logic [7:0] weight,
                       logic [23:0] len, logic tend);
      int gap;
      req_cmd <= cmd;
      req_from_node <= from;
      req_to_node <= to;
      req_fill_value <= fillv;
      req_rank_weight <= weight;
      req_tour_length <= len;
      req_tour_end <= tend;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note(cmd, from, to, fillv, weight, len, tend);
      items_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_simple(logic [2:0] cmd, int from, int to);
      send(cmd, 7'(from), 7'(to), $urandom, 8'($urandom), 24'($urandom),
           1'($urandom_range(0, 1)));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic setup(logic [15:0] rho, logic [15:0] delta, logic [7:0] nodes);
      drain();
      write_reg(REG_RHO, rho);
      write_reg(REG_DELTA, delta);
      write_reg(REG_NODES, {8'($urandom), nodes});
      csr_valid <= 0;
      @(posedge clock);
      phases_run++;
      send(CMD_FILL, 7'($urandom), 7'($urandom), $urandom, 8'($urandom),
           24'($urandom), 1'($urandom));
   endtask

   task automatic random_items(int count);
      int n, r, k, from, to, nxt;
      logic [7:0]  weight;
      logic [23:0] len;
      n = sb.side();
      while (count > 0) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            k = $urandom_range(1, 2 * n);
            weight = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom);
            len = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 4))
                                              : 24'($urandom);
            from = $urandom_range(0, n - 1);
            for (int i = 0; i < k; i++) begin
               nxt = $urandom_range(0, n - 1);
               send(CMD_DEPOSIT, 7'(from), 7'(nxt), $urandom, weight, len, i == k - 1);
               from = nxt;
            end
            count -= k;
         end else begin
            if (r < 65)
               send_simple(CMD_READ, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
            else if (r < 70)
               send_simple(CMD_READ, $urandom, $urandom);
            else if (r < 77)
               send_simple(CMD_EVAP, $urandom, $urandom);
            else if (r < 83)
               send_simple(CMD_DISTURB, $urandom, $urandom);
            else if (r < 87)
               send(CMD_FILL, 7'($urandom), 7'($urandom),
                    ($urandom_range(0, 1) ? $urandom : 32'hFFFF_FF00 | 8'($urandom)),
                    8'($urandom), 24'($urandom), 1'($urandom));
            else if (r < 95)
               send(CMD_DEPOSIT, 7'($urandom), 7'($urandom), $urandom, 8'($urandom),
                    $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 2)),
                    1'($urandom_range(0, 1)));
            else
               send_simple(3'($urandom_range(5, 7)), $urandom, $urandom);
            count--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      setup(16'd0, 16'd65535, 8'd4);
      send(CMD_FILL, 0, 0, 32'hFFFF_FFFF, 0, 1, 0);
      send(CMD_READ, 0, 0, 0, 0, 0, 0);
      send(CMD_READ, 3, 3, 0, 0, 0, 0);
      send(CMD_READ, 127, 0, 0, 0, 0, 0);
      send(CMD_READ, 0, 4, 0, 0, 0, 0);
      send(CMD_DEPOSIT, 1, 2, 0, 8'd255, 24'd1, 1);
      send(CMD_FILL, 0, 0, 32'h0100_0000, 0, 1, 0);
      send(CMD_DEPOSIT, 2, 1, 0, 8'd3, 24'd0, 0);
      send(CMD_DEPOSIT, 4, 1, 0, 8'd9, 24'd2, 1);
      send(CMD_DEPOSIT, 0, 127, 0, 8'd9, 24'd2, 0);
      send(CMD_DEPOSIT, 0, 1, 0, 8'd0, 24'hFFFFFF, 1);
      send(CMD_DEPOSIT, 0, 3, 0, 8'd1, 24'hFFFFFF, 0);
      send(CMD_EVAP, 0, 0, 0, 0, 1, 0);
      send(CMD_READ, 2, 1, 0, 0, 0, 0);
      send(CMD_DISTURB, 0, 0, 0, 0, 1, 0);
      send(CMD_READ, 1, 2, 0, 0, 0, 0);
      send(CMD_READ, 3, 0, 0, 0, 0, 0);
      send(CMD_FILL, 0, 0, 32'd0, 0, 1, 0);
      send(CMD_READ, 1, 1, 0, 0, 0, 0);
      send(3'd5, 1, 1, 0, 0, 1, 1);
      send(3'd6, 1, 1, 0, 0, 1, 1);
      send(3'd7, 1, 1, 0, 0, 1, 1);
      random_items(150);

      setup(16'd65535, 16'd0, 8'd2);
      random_items(180);
      setup(16'($urandom), 16'($urandom), 8'd0);
      random_items(160);
      setup(16'($urandom), 16'($urandom), 8'd3);
      random_items(180);
      setup(16'($urandom), 16'($urandom), 8'd8);
      random_items(180);
      setup(16'($urandom), 16'($urandom), 8'd1);
      random_items(160);
      setup(16'($urandom), 16'($urandom), 8'd5);
      random_items(180);
      setup(16'($urandom), 16'($urandom), 8'd7);
      random_items(180);

      setup(16'($urandom), 16'($urandom), 8'd128);
      for (int i = 0; i < 8; i++)
         send(CMD_DEPOSIT, 7'($urandom), 7'($urandom), $urandom, 8'($urandom),
              24'($urandom_range(0, 3)), i == 7);
      send_simple(CMD_EVAP, 0, 0);
      send_simple(CMD_DISTURB, 0, 0);
      for (int i = 0; i < 10; i++) send_simple(CMD_READ, $urandom, $urandom);
      send_simple(CMD_READ, 127, 127);

      setup(16'($urandom), 16'($urandom), 8'd255);
      for (int i = 0; i < 10; i++) send_simple(CMD_READ, $urandom, $urandom);

      setup(16'($urandom), 16'($urandom), 8'd6);
      random_items(160);

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d commands over %0d register settings, %0d results checked.",
               items_sent, phases_run, sb.checked);
      $display("Mix: fill %0d, evaporate %0d, deposit %0d, disturb %0d, read %0d, %0d saturated.",
               sb.per_cmd[CMD_FILL], sb.per_cmd[CMD_EVAP], sb.per_cmd[CMD_DEPOSIT],
               sb.per_cmd[CMD_DISTURB], sb.per_cmd[CMD_READ], sb.saturations);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
